FILE: design/sgu_pkg.sv
// Shared constants, types and codes of the signed permutation gather unit.
`timescale 1ns / 1ps
package sgu_pkg;

	localparam int DEGREE     = 4096;
	localparam int COEFF_BITS = 60;
	localparam int ADDR_W     = (DEGREE > 1) ? $clog2(DEGREE) : 1;
	localparam int LOAD_IDX_W = 12;
	localparam int MAP_W      = 13;

	typedef logic [COEFF_BITS-1:0] coeff_t;
	typedef logic [ADDR_W-1:0]     addr_t;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_GATHER = 1'b1
	} op_t;

	// Control of a gather whose store read is in flight.
	typedef struct packed {
		logic valid;
		logic neg;
		logic oor;
		logic last;
	} gather_ctl_t;

endpackage

FILE: design/sgu_channels.sv
// Channel interfaces of the signed permutation gather unit.
`timescale 1ns / 1ps

interface sgu_item_if import sgu_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic                        opcode;
	logic [LOAD_IDX_W-1:0]       load_index;
	coeff_t                      coefficient;
	logic signed [MAP_W-1:0]     map_entry;
	logic                        last_in;

	modport source (output valid, opcode, load_index, coefficient, map_entry, last_in,
		input ready);
	modport sink (input valid, opcode, load_index, coefficient, map_entry, last_in,
		output ready);
endinterface

interface sgu_result_if import sgu_pkg::*; ();
	logic   valid;
	logic   ready;
	coeff_t result_value;
	logic   last_out;

	modport source (output valid, result_value, last_out, input ready);
	modport sink (input valid, result_value, last_out, output ready);
endinterface

interface sgu_cfg_if import sgu_pkg::*; ();
	logic   valid;
	logic   ready;
	coeff_t modulus;

	modport source (output valid, modulus, input ready);
	modport sink (input valid, modulus, output ready);
endinterface

FILE: design/sgu_coeff_ram.sv
// Coefficient store: one write port and one registered read port.
`timescale 1ns / 1ps
module sgu_coeff_ram import sgu_pkg::*; (
	input  logic   clk,
	input  logic   wr_en,
	input  addr_t  wr_addr,
	input  coeff_t wr_data,
	input  logic   rd_en,
	input  addr_t  rd_addr,
	output coeff_t rd_data
);

	coeff_t mem [DEGREE];
	coeff_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: design/sgu_out_stage.sv
// Output stage: applies the sign of the map entry and holds the result for the sink.
`timescale 1ns / 1ps
module sgu_out_stage import sgu_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  gather_ctl_t  ctl_s1,
	input  coeff_t       rd_data,
	input  coeff_t       modulus,
	output logic         take,
	sgu_result_if.source results
);

	logic   valid_q;
	coeff_t value_q;
	logic   last_q;
	coeff_t src_val;
	coeff_t res_val;

	// The stage is free when empty or when its current result leaves this cycle.
	assign take = ctl_s1.valid && (!valid_q || results.ready);

	always_comb begin
		src_val = ctl_s1.oor ? '0 : rd_data;
		res_val = ctl_s1.neg ? coeff_t'(modulus - src_val) : src_val;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (results.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			value_q <= res_val;
			last_q  <= ctl_s1.last;
		end
	end

	assign results.valid        = valid_q;
	assign results.result_value = value_q;
	assign results.last_out     = last_q;

endmodule

FILE: design/signed_permutation_gather_unit.sv
// Top level of the signed permutation gather unit.
`timescale 1ns / 1ps
//
//  Channel   Direction  Transaction carries
//  --------  ---------  ---------------------------------------------------------
//  items     in         opcode, load_index, coefficient, map_entry, last_in
//  results   out        result_value, last_out (one per gather, none per load)
//  cfg       in         modulus (the single configuration register)
//
//  A load or gather transaction is taken every cycle while the pipeline flows.
//  A gather result passes through the registered read of the coefficient
//  memory and then the negation into the output register. Reset clears control
//  state and sets the modulus to 2; the memory keeps no reset value. A stalled
//  results sink holds the output register, then the read stage, and only then
//  lowers items.ready.
//
module signed_permutation_gather_unit import sgu_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	sgu_cfg_if.sink      cfg,
	sgu_item_if.sink     items,
	sgu_result_if.source results
);

	// Configuration: the modulus register. Writes must only arrive while idle;
	// the block itself does not enforce this, and the port never pushes back.
	coeff_t modulus_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= coeff_t'(2);
		end else if (cfg.valid) begin
			modulus_q <= cfg.modulus;
		end
	end

	// Input decode. The magnitude of a negative map entry is taken in
	// MAP_W bits, so the most negative entry yields a magnitude of 2^(MAP_W-1)
	// which falls outside the store and reads as zero.
	logic              accept;
	logic              is_gather;
	logic [MAP_W-1:0]  mag;
	logic [31:0]       mag_ext;
	logic [31:0]       ld_ext;
	logic              mag_oor;
	logic              wr_en;
	logic              rd_en;
	logic              take;
	gather_ctl_t       ctl_s1;
	coeff_t            rd_data;

	assign accept    = items.valid && items.ready;
	assign is_gather = (op_t'(items.opcode) == OP_GATHER);

	always_comb begin
		mag     = items.map_entry[MAP_W-1] ? MAP_W'(-items.map_entry) : items.map_entry;
		mag_ext = 32'(mag);
		ld_ext  = 32'(items.load_index);
		mag_oor = (mag_ext >= 32'(DEGREE));
	end

	// A load beyond the store is dropped without effect.
	assign wr_en = accept && !is_gather && (ld_ext < 32'(DEGREE));
	assign rd_en = accept && is_gather;

	// Writes and reads are both taken at the acceptance edge of their own
	// transaction, so a gather always sees every earlier load and no
	// forwarding path is required.
	sgu_coeff_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (ld_ext[ADDR_W-1:0]),
		.wr_data (items.coefficient),
		.rd_en   (rd_en),
		.rd_addr (mag_ext[ADDR_W-1:0]),
		.rd_data (rd_data)
	);

	// Read stage control: travels alongside the registered memory data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (rd_en) begin
			ctl_s1 <= '{valid: 1'b1, neg: items.map_entry[MAP_W-1], oor: mag_oor,
				last: items.last_in};
		end else if (take) begin
			ctl_s1.valid <= 1'b0;
		end
	end

	// The read data register only updates on a new gather, so a held read
	// stage keeps its data intact while the output is stalled.
	assign items.ready = !ctl_s1.valid || take;

	sgu_out_stage u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_s1  (ctl_s1),
		.rd_data (rd_data),
		.modulus (modulus_q),
		.take    (take),
		.results (results)
	);

endmodule

FILE: design/sgu_checker.sv
// Port-level checks of the signed permutation gather unit and their binding.
`timescale 1ns / 1ps
module sgu_checker import sgu_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   items_valid,
	input logic   items_ready,
	input logic   items_opcode,
	input logic   items_last_in,
	input logic   results_valid,
	input logic   results_ready,
	input coeff_t results_value,
	input logic   results_last
);

	logic gather_acc;

	assign gather_acc = items_valid && items_ready &&
		(op_t'(items_opcode) == OP_GATHER);

	// A fresh result always follows an accepted gather, by way of the read stage and the output register.
	a_result_from_gather: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(results_valid) |-> $past(gather_acc, 2))
		else $error("result appeared without a gather transaction");

	// The last marker of a fresh result belongs to that gather.
	a_last_follows: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(results_valid) |-> (results_last == $past(items_last_in, 2)))
		else $error("last_out does not match last_in of its gather");

	// Input back-pressure only arises from a stalled results sink.
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!items_ready |-> (results_valid && !results_ready))
		else $error("items.ready low without a stalled result");

	// A stalled result keeps its contents.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(results_valid && !results_ready) |=>
		(results_valid && $stable(results_value) && $stable(results_last)))
		else $error("stalled result changed");

endmodule

bind signed_permutation_gather_unit sgu_checker u_sgu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.items_valid   (items.valid),
	.items_ready   (items.ready),
	.items_opcode  (items.opcode),
	.items_last_in (items.last_in),
	.results_valid (results.valid),
	.results_ready (results.ready),
	.results_value (results.result_value),
	.results_last  (results.last_out)
);

FILE: tb/tb_signed_permutation_gather_unit.sv
// Self-checking testbench of the signed permutation gather unit.
`timescale 1ns / 1ps

module tb_signed_permutation_gather_unit;
	import sgu_pkg::*;

	localparam coeff_t COEFF_MAX       = '1;
	localparam int     NUM_PHASES      = 5;
	localparam int     ITEMS_PER_PHASE = 80;
	// Spare cycles after the last result, to cover loads in flight.
	localparam int     SETTLE_CYCLES   = 6;

	typedef logic signed [MAP_W-1:0] map_t;

	// One row of stimulus. When "fixed" is set, the expected result is typed into the row
	// and replaces the predictor's answer for that gather.
	typedef struct {
		op_t                   op;
		logic [LOAD_IDX_W-1:0] load_index;
		coeff_t                coefficient;
		map_t                  map_entry;
		logic                  last_in;
		bit                    fixed;
		coeff_t                fixed_value;
	} stim_row_t;

	typedef struct {
		coeff_t value;
		logic   last;
	} gathered_coeff_t;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic clk = 1'b0;
	logic arst_n;

	sgu_cfg_if    cfg_ch ();
	sgu_item_if   items_ch ();
	sgu_result_if results_ch ();

	signed_permutation_gather_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.items   (items_ch),
		.results (results_ch)
	);

	// Period of 2 ns: one nanosecond low, one high.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predictor state: a private copy of the coefficient store and of the modulus.
	coeff_t model_store [DEGREE];
	coeff_t model_modulus;
	gathered_coeff_t pending_results [$];

	// Stimulus-side bookkeeping of which store entries have been loaded. Items are accepted
	// in the order in which they are generated, so this view matches the block's own.
	bit is_loaded [DEGREE];
	int loaded_idx [$];

	// Typed expectation travelling alongside the transaction that is on offer.
	bit     row_fixed;
	coeff_t row_fixed_value;

	int mismatches  = 0;
	int items_sent  = 0;
	int burst_left  = 0;
	bit no_gaps     = 1'b0;
	int hold_cycles = 0;

	stim_row_t directed_rows [20] = '{
		// Loads covering both ends of the index range and of the coefficient range.
		'{OP_LOAD,   12'd0,    '0,                    13'sd0, 1'b0, 1'b0, '0},
		'{OP_LOAD,   12'd4095, COEFF_MAX,             13'sd0, 1'b0, 1'b0, '0},
		'{OP_LOAD,   12'd1,    60'd5,                 13'sd0, 1'b0, 1'b0, '0},
		'{OP_LOAD,   12'd2,    60'hAAA_AAAA_AAAA_AAAA, 13'sd0, 1'b0, 1'b0, '0},
		'{OP_LOAD,   12'd3,    60'h555_5555_5555_5555, 13'sd0, 1'b0, 1'b0, '0},
		// A load with last_in set, which the block must ignore.
		'{OP_LOAD,   12'd5,    '0,                    13'sd0, 1'b1, 1'b0, '0},
		// The modulus is still at its reset value of 2 here.
		'{OP_GATHER, 12'd0,    '0, 13'sd0,     1'b0, 1'b1, '0},
		'{OP_GATHER, 12'd0,    '0, 13'sd4095,  1'b0, 1'b1, COEFF_MAX},
		// Coefficient far above the modulus: the negation wraps round 2^60.
		'{OP_GATHER, 12'd0,    '0, -13'sd4095, 1'b0, 1'b1, 60'd3},
		'{OP_GATHER, 12'd0,    '0, -13'sd1,    1'b0, 1'b1, 60'hFFF_FFFF_FFFF_FFFD},
		// The most negative entry points past the store and so reads zero.
		'{OP_GATHER, 12'd0,    '0, 13'h1000,   1'b0, 1'b1, 60'd2},
		// A stored zero read through a negative entry gives the modulus itself.
		'{OP_GATHER, 12'd0,    '0, -13'sd5,    1'b0, 1'b1, 60'd2},
		'{OP_GATHER, 12'd0,    '0, 13'sd1,     1'b1, 1'b1, 60'd5},
		'{OP_GATHER, 12'd0,    '0, 13'sd2,     1'b0, 1'b0, '0},
		'{OP_GATHER, 12'd0,    '0, -13'sd2,    1'b0, 1'b0, '0},
		'{OP_GATHER, 12'd0,    '0, 13'sd3,     1'b0, 1'b0, '0},
		'{OP_GATHER, 12'd0,    '0, -13'sd3,    1'b1, 1'b0, '0},
		// Overwrite an entry and read it back at once, in both signs.
		'{OP_LOAD,   12'd1,    60'h123_4567_89AB_CDEF, 13'sd0, 1'b0, 1'b0, '0},
		'{OP_GATHER, 12'd0,    '0, 13'sd1,     1'b0, 1'b0, '0},
		'{OP_GATHER, 12'd0,    '0, -13'sd1,    1'b1, 1'b0, '0}
	};

	// Expected coefficient of a gather: a negative entry negates the source modulo the
	// modulus, and a source index beyond the store reads zero.
	function automatic coeff_t gathered_value(map_t entry);
		bit     neg;
		int     src;
		coeff_t stored;
		neg    = entry[MAP_W-1];
		src    = neg ? -int'(entry) : int'(entry);
		stored = (src < DEGREE) ? model_store[src] : '0;
		return neg ? coeff_t'(model_modulus - stored) : stored;
	endfunction

	task automatic report_mismatch(string what, coeff_t got, coeff_t want);
		$display("%0t ns: mismatch in %s: got 0x%h, expected 0x%h", $time, what, got, want);
		mismatches++;
	endtask

	// Monitor: every accepted transaction on any channel is seen here at the rising edge.
	always @(posedge clk) begin : monitor
		gathered_coeff_t want;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				model_modulus = cfg_ch.modulus;
			if (items_ch.valid && items_ch.ready) begin
				if (items_ch.opcode == OP_LOAD) begin
					if (int'(items_ch.load_index) < DEGREE)
						model_store[items_ch.load_index] = items_ch.coefficient;
				end else begin
					want.value = row_fixed ? row_fixed_value : gathered_value(items_ch.map_entry);
					want.last  = items_ch.last_in;
					pending_results.push_back(want);
				end
			end
			if (results_ch.valid && results_ch.ready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result", results_ch.result_value, '0);
				end else begin
					want = pending_results.pop_front();
					if (results_ch.result_value !== want.value)
						report_mismatch("result_value", results_ch.result_value, want.value);
					if (results_ch.last_out !== want.last)
						report_mismatch("last_out", coeff_t'(results_ch.last_out),
							coeff_t'(want.last));
				end
			end
		end
	end

	// The receiver switches between random stall patterns. A long hold requested by the
	// stimulus is counted down here, at each falling edge.
	initial begin : receiver
		stall_mode_t mode;
		int          mode_left;
		int          tick;
		mode_left = 0;
		tick      = 0;
		mode      = STALL_NONE;
		results_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			tick++;
			if (hold_cycles > 0) begin
				hold_cycles--;
				results_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = stall_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 120);
				end
				mode_left--;
				case (mode)
					STALL_NONE:  results_ch.ready <= 1'b1;
					STALL_LIGHT: results_ch.ready <= ($urandom_range(0, 9) < 8);
					STALL_HEAVY: results_ch.ready <= ($urandom_range(0, 9) < 3);
					default:     results_ch.ready <= ((tick % 5) != 0);
				endcase
			end
		end
	end

	// Offers one transaction and waits until it is taken. Bursts of random length are
	// separated by random gaps in which valid is low, unless no_gaps is set.
	task automatic send_item(stim_row_t r);
		int gap;
		if (burst_left == 0) begin
			gap = no_gaps ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				@(negedge clk);
				items_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		@(negedge clk);
		items_ch.valid       <= 1'b1;
		items_ch.opcode      <= r.op;
		items_ch.load_index  <= r.load_index;
		items_ch.coefficient <= r.coefficient;
		items_ch.map_entry   <= r.map_entry;
		items_ch.last_in     <= r.last_in;
		row_fixed            <= r.fixed;
		row_fixed_value      <= r.fixed_value;
		@(posedge clk);
		while (!items_ch.ready) @(posedge clk);
		burst_left--;
		items_sent++;
		if (r.op == OP_LOAD && !is_loaded[r.load_index]) begin
			is_loaded[r.load_index] = 1'b1;
			loaded_idx.push_back(int'(r.load_index));
		end
	endtask

	// Lowers valid and waits until every expected result has arrived and any load still in
	// the pipeline has had time to land in the store.
	task automatic drain_pipeline();
		@(negedge clk);
		items_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic write_modulus(coeff_t value);
		@(negedge clk);
		cfg_ch.valid   <= 1'b1;
		cfg_ch.modulus <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	// Coefficients cluster on zero, all ones and values below the modulus, with plenty of
	// unrestricted 60-bit values besides.
	function automatic coeff_t rand_coeff();
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return COEFF_MAX;
			2:       return coeff_t'({$urandom, $urandom} % {4'b0, model_modulus});
			default: return coeff_t'({$urandom, $urandom});
		endcase
	endfunction

	function automatic coeff_t phase_modulus(int phase);
		coeff_t m;
		case (phase)
			0:       m = COEFF_MAX;
			1:       m = 60'd2;
			2:       m = coeff_t'({$urandom, $urandom});
			3:       m = coeff_t'($urandom_range(3, 1000));
			default: m = coeff_t'({$urandom, $urandom}) | {1'b1, {(COEFF_BITS-1){1'b0}}};
		endcase
		return (m < 2) ? 60'd2 : m;
	endfunction

	// A gather row that only ever reads a loaded entry, or the out-of-range source.
	function automatic stim_row_t gather_row(int src, bit neg, logic last);
		stim_row_t r;
		r.op          = OP_GATHER;
		r.load_index  = LOAD_IDX_W'($urandom);
		r.coefficient = coeff_t'({$urandom, $urandom});
		r.map_entry   = neg ? -map_t'(src) : map_t'(src);
		r.last_in     = last;
		r.fixed       = 1'b0;
		r.fixed_value = '0;
		return r;
	endfunction

	function automatic stim_row_t load_row(int idx);
		stim_row_t r;
		r.op          = OP_LOAD;
		r.load_index  = LOAD_IDX_W'(idx);
		r.coefficient = rand_coeff();
		r.map_entry   = map_t'($urandom);
		r.last_in     = $urandom_range(0, 1);
		r.fixed       = 1'b0;
		r.fixed_value = '0;
		return r;
	endfunction

	// A small polynomial: load a run of coefficients, then gather it through a random
	// signed map, with last_in on the final gather.
	task automatic send_polynomial();
		int n;
		int base;
		n    = $urandom_range(2, 16);
		base = $urandom_range(0, DEGREE - n);
		for (int i = 0; i < n; i++)
			send_item(load_row(base + i));
		for (int i = 0; i < n; i++)
			send_item(gather_row(base + $urandom_range(0, n - 1), $urandom_range(0, 1),
				i == n - 1));
	endtask

	// Unstructured traffic: loads anywhere, gathers from any loaded entry, and now and then
	// the most negative map entry.
	task automatic send_noise();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 4 || loaded_idx.size() == 0)
			send_item(load_row(($urandom_range(0, 1) != 0) ? $urandom_range(0, 63)
				: $urandom_range(0, DEGREE - 1)));
		else if (pick == 4)
			send_item(gather_row(DEGREE, 1'b1, $urandom_range(0, 1)));
		else
			send_item(gather_row(loaded_idx[$urandom_range(0, loaded_idx.size() - 1)],
				$urandom_range(0, 1), $urandom_range(0, 1)));
	endtask

	initial begin : stimulus
		int phase_end;
		arst_n               = 1'b0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.modulus       = '0;
		items_ch.valid       = 1'b0;
		items_ch.opcode      = OP_LOAD;
		items_ch.load_index  = '0;
		items_ch.coefficient = '0;
		items_ch.map_entry   = '0;
		items_ch.last_in     = 1'b0;
		row_fixed            = 1'b0;
		row_fixed_value      = '0;
		model_modulus        = 60'd2;
		for (int i = 0; i < DEGREE; i++) begin
			model_store[i] = '0;
			is_loaded[i]   = 1'b0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// The directed rows run against the modulus as it comes out of reset.
		foreach (directed_rows[i])
			send_item(directed_rows[i]);

		for (int p = 0; p < NUM_PHASES; p++) begin
			// The sender pauses here until every expected result has come back.
			drain_pipeline();
			write_modulus(phase_modulus(p));
			no_gaps = (p == 1 || p == 3);
			// In one phase the receiver holds off for a long stretch while the sender keeps
			// offering, so that the block fills up and stops taking transactions.
			if (p == 1)
				hold_cycles = 120;
			phase_end = items_sent + ITEMS_PER_PHASE;
			while (items_sent < phase_end) begin
				if ($urandom_range(0, 3) != 0)
					send_polynomial();
				else
					repeat ($urandom_range(1, 8)) send_noise();
			end
		end

		drain_pipeline();
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// The time limit lies far beyond the slowest correct run.
	initial begin : watchdog
		#400000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: files.f
design/sgu_pkg.sv
design/sgu_channels.sv
design/sgu_coeff_ram.sv
design/sgu_out_stage.sv
design/signed_permutation_gather_unit.sv
design/sgu_checker.sv
tb/tb_signed_permutation_gather_unit.sv
